// File: sv/lfpd_pkg.sv
package lfpd_pkg;

  localparam int FRAC_BITS = 12;

  localparam int READ_W = 12;
  localparam int SUM_W  = 14;
  localparam int WSUM_W = 16;
  localparam int QUO_W  = FRAC_BITS + 2;
  localparam int ERR_W  = 15;
  localparam int INT_W  = 15;
  localparam int DIFF_W = 16;
  localparam int GAIN_W = 16;
  localparam int ACC_W  = 34;
  localparam int CORR_W = ACC_W - FRAC_BITS;
  localparam int DRV_W  = 16;
  localparam int OUT_W  = 18;
  localparam int BIAS_W = 12;
  localparam int LIM_W  = 14;
  localparam int CNT_W  = 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [READ_W-1:0] BLACK_LEVEL  = READ_W'((4 * (2 ** FRAC_BITS) + 5) / 10);
  localparam logic [READ_W-1:0] FORCED_LEVEL = READ_W'((76 * (2 ** FRAC_BITS) + 50) / 100);
  localparam logic [ERR_W-1:0]  LOST_POS     = ERR_W'((15 * (2 ** FRAC_BITS) + 50) / 100);
  localparam logic [ERR_W-1:0]  BIAS_EDGE    = ERR_W'((5 * (2 ** FRAC_BITS) + 50) / 100);

  localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd2662;
  localparam logic [GAIN_W-1:0] GAIN_I_RST   = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd696;
  localparam logic [DRV_W-1:0]  FLOOR_RST    = 16'd12288;
  localparam logic [DRV_W-1:0]  CEILING_RST  = 16'd40960;
  localparam logic [BIAS_W-1:0] BIAS_RST     = 12'd2376;
  localparam logic [LIM_W-1:0]  LIMIT_RST    = 14'd1229;

  typedef enum logic [1:0] {
    OVR_NONE    = 2'd0,
    OVR_SENSOR0 = 2'd1,
    OVR_SENSOR3 = 2'd2
  } ovr_t;

  typedef enum logic [2:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_DRIVE_FLOOR    = 3'd3,
    REG_DRIVE_CEILING  = 3'd4,
    REG_STEER_BIAS     = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6
  } reg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_ERR   = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_CLAMP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

// File: sv/line_follow_pid_drive_top.sv
// A request is taken only in idle, where its readings are captured. The
// states LOAD, bit-serial divide (one quotient bit per cycle, 14 bits),
// ERR, bit-serial PID multiply (one gain bit per cycle, 16 gain bits),
// CLAMP and DONE follow; in_stall stays high until DONE loads the result.
// Reset is synchronous: it restores the register defaults and clears the
// previous error, the error integral and the output valid.
module line_follow_pid_drive_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lfpd_pkg::READ_W-1:0]           reading_a,
  input  logic [lfpd_pkg::READ_W-1:0]           reading_b,
  input  logic [lfpd_pkg::READ_W-1:0]           reading_c,
  input  logic [lfpd_pkg::READ_W-1:0]           reading_d,
  input  logic [1:0]                            edge_override,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lfpd_pkg::OUT_W-1:0]     left_drive,
  output logic signed [lfpd_pkg::OUT_W-1:0]     right_drive,
  output logic signed [lfpd_pkg::ERR_W-1:0]     position_error,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lfpd_pkg::ADDR_W-1:0]           paddr,
  input  logic [lfpd_pkg::DATA_W-1:0]           pwdata,
  output logic [lfpd_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);
  import lfpd_pkg::*;

  state_t state;
  state_t state_next;
  logic [CNT_W-1:0] cnt;

  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  logic [DRV_W-1:0]  drive_floor;
  logic [DRV_W-1:0]  drive_ceiling;
  logic [BIAS_W-1:0] steer_bias;
  logic [LIM_W-1:0]  integral_limit;

  logic signed [ERR_W-1:0] previous_error;
  logic signed [INT_W-1:0] error_integral;

  logic [READ_W-1:0] s0;
  logic [READ_W-1:0] s1;
  logic [READ_W-1:0] s2;
  logic [READ_W-1:0] s3;

  logic              w_neg;
  logic [SUM_W-1:0]  sum;
  logic              all_high;
  logic [SUM_W-1:0]  rem;
  logic [QUO_W-1:0]  dsr;
  logic [QUO_W-1:0]  quo;

  logic signed [ERR_W-1:0]  err;
  logic signed [INT_W-1:0]  integ;
  logic signed [DIFF_W-1:0] diff;
  logic [GAIN_W-1:0]        gp_sr;
  logic [GAIN_W-1:0]        gi_sr;
  logic [GAIN_W-1:0]        gd_sr;
  logic signed [ACC_W-1:0]  acc;

  logic [DRV_W-1:0] right_c;
  logic [DRV_W-1:0] left_c;

  logic [READ_W-1:0] r0;
  logic [READ_W-1:0] r3;
  logic [WSUM_W-1:0] e0;
  logic [WSUM_W-1:0] e1;
  logic [WSUM_W-1:0] e2;
  logic [WSUM_W-1:0] e3;
  logic [WSUM_W-1:0] w_calc;
  logic [WSUM_W-1:0] w_abs;
  logic [SUM_W-1:0]  sum_calc;
  logic              all_high_calc;

  logic [SUM_W:0]    shifted;
  logic [SUM_W+1:0]  trial;
  logic              fits;

  logic signed [ERR_W-1:0]  err_div;
  logic signed [ERR_W-1:0]  err_calc;
  logic signed [INT_W:0]    integ_sum;
  logic signed [INT_W:0]    lim_pos;
  logic signed [INT_W:0]    lim_neg;
  logic signed [INT_W-1:0]  integ_next;
  logic signed [DIFF_W-1:0] diff_calc;

  logic signed [ACC_W-1:0]  term_p;
  logic signed [ACC_W-1:0]  term_i;
  logic signed [ACC_W-1:0]  term_d;

  logic signed [CORR_W-1:0] corr;
  logic signed [CORR_W-1:0] corr_neg;

  logic [OUT_W-1:0] right_ext;
  logic [OUT_W-1:0] left_ext;
  logic [OUT_W-1:0] bias_ext;
  logic             bias_up;
  logic             bias_down;

  logic cfg_write;
  logic out_load;

  function automatic logic [DRV_W-1:0] clamp_drive(
    input logic signed [CORR_W-1:0] v,
    input logic [DRV_W-1:0]         lo,
    input logic [DRV_W-1:0]         hi
  );
    logic signed [CORR_W-1:0] lo_s;
    logic signed [CORR_W-1:0] hi_s;
    logic [DRV_W-1:0]         res;
    lo_s = $signed({{(CORR_W - DRV_W){1'b0}}, lo});
    hi_s = $signed({{(CORR_W - DRV_W){1'b0}}, hi});
    if (v < lo_s) begin
      res = lo;
    end else if (v > hi_s) begin
      res = hi;
    end else begin
      res = v[DRV_W-1:0];
    end
    return res;
  endfunction

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = (state != ST_IDLE);
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    r0 = reading_a;
    r3 = reading_d;
    case (ovr_t'(edge_override))
      OVR_SENSOR0: r0 = FORCED_LEVEL;
      OVR_SENSOR3: r3 = FORCED_LEVEL;
      default: begin
      end
    endcase
  end

  always_comb begin
    e0 = {{(WSUM_W - READ_W){1'b0}}, s0};
    e1 = {{(WSUM_W - READ_W){1'b0}}, s1};
    e2 = {{(WSUM_W - READ_W){1'b0}}, s2};
    e3 = {{(WSUM_W - READ_W){1'b0}}, s3};
    w_calc = (e0 + (e0 << 1) + e1) - (e2 + e3 + (e3 << 1));
    w_abs = w_calc[WSUM_W-1] ? (~w_calc + 1'b1) : w_calc;
    sum_calc = SUM_W'(e0 + e1 + e2 + e3);
    all_high_calc = (s0 >= BLACK_LEVEL) && (s1 >= BLACK_LEVEL)
                    && (s2 >= BLACK_LEVEL) && (s3 >= BLACK_LEVEL);
  end

  always_comb begin
    shifted = {rem, dsr[QUO_W-1]};
    trial   = {1'b0, shifted} - {2'b00, sum};
    fits    = !trial[SUM_W+1];
  end

  always_comb begin
    err_div = w_neg ? ERR_W'(-{1'b0, quo}) : ERR_W'({1'b0, quo});
    if (all_high) begin
      err_calc = (previous_error > 0) ? $signed(LOST_POS) : $signed(ERR_W'(-LOST_POS));
    end else if (sum == '0) begin
      err_calc = '0;
    end else begin
      err_calc = err_div;
    end
    integ_sum = (INT_W + 1)'(error_integral) + (INT_W + 1)'(err_calc);
    lim_pos   = $signed({{(INT_W + 1 - LIM_W){1'b0}}, integral_limit});
    lim_neg   = -lim_pos;
    if (integ_sum > lim_pos) begin
      integ_next = INT_W'(lim_pos);
    end else if (integ_sum < lim_neg) begin
      integ_next = INT_W'(lim_neg);
    end else begin
      integ_next = INT_W'(integ_sum);
    end
    diff_calc = DIFF_W'(err_calc) - DIFF_W'(previous_error);
  end

  always_comb begin
    term_p = gp_sr[GAIN_W-1] ? ACC_W'(err)   : '0;
    term_i = gi_sr[GAIN_W-1] ? ACC_W'(integ) : '0;
    term_d = gd_sr[GAIN_W-1] ? ACC_W'(diff)  : '0;
    corr     = acc[ACC_W-1:FRAC_BITS];
    corr_neg = -corr;
  end

  always_comb begin
    right_ext = {{(OUT_W - DRV_W){1'b0}}, right_c};
    left_ext  = {{(OUT_W - DRV_W){1'b0}}, left_c};
    bias_ext  = {{(OUT_W - BIAS_W){1'b0}}, steer_bias};
    bias_up   = err > $signed(BIAS_EDGE);
    bias_down = err < $signed(BIAS_EDGE);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == '0) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: state_next = ST_MUL;
      ST_MUL: begin
        if (cnt == '0) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_GAIN_P:         prdata = DATA_W'(gain_p);
      REG_GAIN_I:         prdata = DATA_W'(gain_i);
      REG_GAIN_D:         prdata = DATA_W'(gain_d);
      REG_DRIVE_FLOOR:    prdata = DATA_W'(drive_floor);
      REG_DRIVE_CEILING:  prdata = DATA_W'(drive_ceiling);
      REG_STEER_BIAS:     prdata = DATA_W'(steer_bias);
      REG_INTEGRAL_LIMIT: prdata = DATA_W'(integral_limit);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      previous_error <= '0;
      error_integral <= '0;
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
      drive_floor    <= FLOOR_RST;
      drive_ceiling  <= CEILING_RST;
      steer_bias     <= BIAS_RST;
      integral_limit <= LIMIT_RST;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_ERR) begin
        previous_error <= err_calc;
        error_integral <= integ_next;
      end
      if (cfg_write) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_GAIN_P:         gain_p         <= pwdata[GAIN_W-1:0];
          REG_GAIN_I:         gain_i         <= pwdata[GAIN_W-1:0];
          REG_GAIN_D:         gain_d         <= pwdata[GAIN_W-1:0];
          REG_DRIVE_FLOOR:    drive_floor    <= pwdata[DRV_W-1:0];
          REG_DRIVE_CEILING:  drive_ceiling  <= pwdata[DRV_W-1:0];
          REG_STEER_BIAS:     steer_bias     <= pwdata[BIAS_W-1:0];
          REG_INTEGRAL_LIMIT: integral_limit <= pwdata[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        s0 <= r0;
        s1 <= reading_b;
        s2 <= reading_c;
        s3 <= r3;
      end
      ST_LOAD: begin
        w_neg    <= w_calc[WSUM_W-1];
        sum      <= sum_calc;
        all_high <= all_high_calc;
        rem      <= {2'b00, w_abs[SUM_W-1:2]};
        dsr      <= {w_abs[1:0], {FRAC_BITS{1'b0}}};
        quo      <= '0;
        cnt      <= CNT_W'(QUO_W - 1);
      end
      ST_DIV: begin
        rem <= fits ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
        dsr <= dsr << 1;
        quo <= {quo[QUO_W-2:0], fits};
        cnt <= cnt - 1'b1;
      end
      ST_ERR: begin
        err   <= err_calc;
        integ <= integ_next;
        diff  <= diff_calc;
        gp_sr <= gain_p;
        gi_sr <= gain_i;
        gd_sr <= gain_d;
        acc   <= '0;
        cnt   <= CNT_W'(GAIN_W - 1);
      end
      ST_MUL: begin
        acc   <= (acc <<< 1) + term_p + term_i + term_d;
        gp_sr <= gp_sr << 1;
        gi_sr <= gi_sr << 1;
        gd_sr <= gd_sr << 1;
        cnt   <= cnt - 1'b1;
      end
      ST_CLAMP: begin
        right_c <= clamp_drive(corr, drive_floor, drive_ceiling);
        left_c  <= clamp_drive(corr_neg, drive_floor, drive_ceiling);
      end
      ST_DONE: begin
        if (out_load) begin
          position_error <= err;
          if (bias_up) begin
            right_drive <= $signed(right_ext - bias_ext);
            left_drive  <= $signed(left_ext + bias_ext);
          end else if (bias_down) begin
            right_drive <= $signed(right_ext + bias_ext);
            left_drive  <= $signed(left_ext - bias_ext);
          end else begin
            right_drive <= $signed(right_ext);
            left_drive  <= $signed(left_ext);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
